@@ design/cvk1d_pkg.sv @@
// ----------------------------------------------------------------------------
// cvk1d_pkg
// Shared types, constants and helpers for the 1-D constant-velocity Kalman
// filter: sequencer states, operation codes and 32-bit saturation.
// ----------------------------------------------------------------------------
package cvk1d_pkg;

	// default number of fraction bits of the fixed-point format
	localparam int FRAC_BITS_DEF = 16;

	// smoothing weight: one in Q1.16 and the value after reset
	localparam logic [16:0] W_ONE   = 17'd65536;
	localparam logic [16:0] W_RESET = 17'd1311;

	// dividend width of the bit-serial divider
	localparam int DIV_W = 64;

	// largest 31-bit score
	localparam logic [30:0] SCORE_MAX = 31'h7fff_ffff;

	typedef enum logic [1:0] {
		OP_RESET   = 2'd0,
		OP_PREDICT = 2'd1,
		OP_POS_UPD = 2'd2,
		OP_VEL_UPD = 2'd3
	} op_t;

	// which quotient the divider is producing
	typedef enum logic [1:0] {
		DV_SCORE,
		DV_K0,
		DV_K1
	} dsel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
		S_U0, S_U1, S_SC_START, S_DIV, S_DIVEND,
		S_A0, S_A1, S_A2,
		S_K0_START, S_K1_START,
		S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        ovf;
		logic [31:0] val;
	} sat_t;

	// clip a wide signed value to the 32-bit signed range
	function automatic sat_t sat32(input logic signed [66:0] v);
		sat_t r;
		if (v > 67'sd2147483647) begin
			r.ovf = 1'b1;
			r.val = 32'h7fff_ffff;
		end else if (v < -67'sd2147483648) begin
			r.ovf = 1'b1;
			r.val = 32'h8000_0000;
		end else begin
			r.ovf = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ design/const_velocity_kalman_1d_top.sv @@
// A measurement update runs three 64-step bit-serial divisions (score, two
// gains) on one shared divider, plus products on the shared multiplier.
// One item at a time: a new word is taken once the last result has been
// handed to the output register.
// Reset clears the estimate and covariance, scores to zero, smoothed score to one.
// ----------------------------------------------------------------------------
// const_velocity_kalman_1d_top
// One-axis constant-velocity Kalman filter in saturating signed fixed point.
// A small sequencer drives one registered multiplier and one restoring divider.
// ----------------------------------------------------------------------------
module const_velocity_kalman_1d_top #(
	parameter int FRAC_BITS = cvk1d_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_wr_en,
	input  logic [16:0]        cfg_wr_data,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [16:0]        time_step,
	input  logic [30:0]        pos_noise,
	input  logic [30:0]        vel_noise,
	input  logic signed [31:0] measurement,
	input  logic [30:0]        meas_variance,
	input  logic signed [31:0] init_pos,
	input  logic signed [31:0] init_vel,
	input  logic [30:0]        init_pos_var,
	input  logic [30:0]        init_vel_var,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] est_pos,
	output logic signed [31:0] est_vel,
	output logic signed [31:0] var_pos,
	output logic signed [31:0] cov_cross,
	output logic signed [31:0] var_vel,
	output logic [30:0]        pos_score,
	output logic [30:0]        vel_score,
	output logic [30:0]        pos_score_avg,
	output logic               skipped,
	output logic               saturated
);

	localparam int CNT_W = $clog2(cvk1d_pkg::DIV_W);
	localparam logic signed [66:0] RND_HALF = 67'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [66:0] Q_ONE    = 67'sd1 <<< FRAC_BITS;
	localparam logic [30:0]        AVG_INIT = 31'd1 << FRAC_BITS;

	cvk1d_pkg::state_t state_q, state_d;

	// filter state, also the result word
	logic signed [31:0] pos_q, vel_q, pp_q, pv_q, vv_q;
	logic [30:0]        psc_q, vsc_q, avg_q;
	logic               out_valid_q, skip_out_q, sat_out_q;
	logic [16:0]        weight_q;

	// latched input word
	cvk1d_pkg::op_t     op_q;
	logic [16:0]        dt_q;
	logic [30:0]        qp_q, qv_q, r_q;
	logic signed [31:0] z_q;

	// next state under construction
	logic signed [31:0] n_pos_q, n_vel_q, n_pp_q, n_pv_q, n_vv_q;
	logic [30:0]        n_psc_q, n_vsc_q, n_avg_q;
	logic               sat_q, skip_q;

	// work registers
	logic signed [31:0] y_q, k0_q, k1_q, om_q, m_q;
	logic               m_ovf_q;
	logic signed [32:0] s_q;
	logic signed [49:0] acc_q;
	logic signed [65:0] prod_q;

	// divider
	logic [cvk1d_pkg::DIV_W-1:0] div_q;
	logic [32:0]                 rem_q;
	logic [CNT_W-1:0]            cnt_q;
	cvk1d_pkg::dsel_t            dsel_q;
	logic                        dneg_q;

	// combinational helpers
	logic signed [32:0] mul_a, mul_b;
	logic               is_vel, accept;
	logic [16:0]        wc;
	logic [31:0]        y_abs, s_half, a_abs0, a_abs1;
	logic signed [66:0] rsum, rsh;
	cvk1d_pkg::sat_t    rnd_s, y_s, om_s;
	logic [33:0]        div_sh;
	logic [34:0]        div_tr;
	logic               k_big;
	logic [31:0]        k_mag, k_val;
	logic               k_ovf;
	cvk1d_pkg::sat_t    t_pos, t_vel, t_pp_p, t_pv_p, t_vv_p, t_pp_u, t_pv_u, t_vv_u;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == cvk1d_pkg::S_IDLE);
	assign is_vel   = (op_q == cvk1d_pkg::OP_VEL_UPD);
	assign wc       = (weight_q > cvk1d_pkg::W_ONE) ? cvk1d_pkg::W_ONE : weight_q;
	assign y_abs    = y_q[31] ? 32'(-y_q) : 32'(y_q);
	assign s_half   = 32'(s_q[32:1]);
	assign a_abs0   = is_vel ? (pv_q[31] ? 32'(-pv_q) : 32'(pv_q))
	                         : (pp_q[31] ? 32'(-pp_q) : 32'(pp_q));
	assign a_abs1   = is_vel ? (vv_q[31] ? 32'(-vv_q) : 32'(vv_q))
	                         : (pv_q[31] ? 32'(-pv_q) : 32'(pv_q));

	// round the product to nearest, ties up, and clip
	assign rsum  = 67'(prod_q) + RND_HALF;
	assign rsh   = rsum >>> FRAC_BITS;
	assign rnd_s = cvk1d_pkg::sat32(rsh);

	// innovation and one-minus-gain
	assign y_s  = cvk1d_pkg::sat32(67'(z_q) - 67'(is_vel ? vel_q : pos_q));
	assign om_s = cvk1d_pkg::sat32(Q_ONE - 67'(is_vel ? k1_q : k0_q));

	// one restoring divider step
	assign div_sh = {rem_q, div_q[cvk1d_pkg::DIV_W-1]};
	assign div_tr = {1'b0, div_sh} - {2'b00, s_q};

	// gain from the quotient: clip the magnitude to 2^31, then the sign
	assign k_big = (|div_q[cvk1d_pkg::DIV_W-1:32]) || (div_q[31] && (|div_q[30:0]));
	assign k_mag = k_big ? 32'h8000_0000 : div_q[31:0];
	always_comb begin
		if (dneg_q) begin
			k_val = 32'(-k_mag);
			k_ovf = 1'b0;
		end else if (k_mag[31]) begin
			k_val = 32'h7fff_ffff;
			k_ovf = 1'b1;
		end else begin
			k_val = k_mag;
			k_ovf = 1'b0;
		end
	end

	// final sums of the update and predict steps
	assign t_pos  = cvk1d_pkg::sat32(67'(pos_q) + 67'(m_q));
	assign t_vel  = cvk1d_pkg::sat32(67'(vel_q) + 67'(m_q));
	assign t_pp_u = cvk1d_pkg::sat32(67'(pp_q) - 67'(m_q));
	assign t_pv_u = cvk1d_pkg::sat32(67'(pv_q) - 67'(m_q));
	assign t_vv_u = cvk1d_pkg::sat32(67'(vv_q) - 67'(m_q));
	assign t_pp_p = cvk1d_pkg::sat32(67'(acc_q) + 67'(m_q));
	assign t_pv_p = cvk1d_pkg::sat32(67'(pv_q) + 67'(m_q));
	assign t_vv_p = cvk1d_pkg::sat32(67'(vv_q) + 67'(qv_q));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cvk1d_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and multiplier operands
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			cvk1d_pkg::S_IDLE: begin
				if (accept) begin
					unique case (cvk1d_pkg::op_t'(op))
						cvk1d_pkg::OP_RESET:   state_d = cvk1d_pkg::S_DONE;
						cvk1d_pkg::OP_PREDICT: state_d = cvk1d_pkg::S_P0;
						default:               state_d = cvk1d_pkg::S_U0;
					endcase
				end
			end
			cvk1d_pkg::S_P0: begin
				mul_a   = 33'(vel_q);
				mul_b   = 33'(dt_q);
				state_d = cvk1d_pkg::S_P1;
			end
			cvk1d_pkg::S_P1: begin
				mul_a   = 33'(dt_q);
				mul_b   = 33'(pv_q);
				state_d = cvk1d_pkg::S_P2;
			end
			cvk1d_pkg::S_P2: begin
				mul_a   = 33'(dt_q);
				mul_b   = 33'(dt_q);
				state_d = cvk1d_pkg::S_P3;
			end
			cvk1d_pkg::S_P3: begin
				mul_a   = 33'(dt_q);
				mul_b   = 33'(vv_q);
				state_d = cvk1d_pkg::S_P4;
			end
			cvk1d_pkg::S_P4: begin
				mul_a   = 33'(m_q);
				mul_b   = 33'(vv_q);
				state_d = cvk1d_pkg::S_P5;
			end
			cvk1d_pkg::S_P5: state_d = cvk1d_pkg::S_P6;
			cvk1d_pkg::S_P6: state_d = cvk1d_pkg::S_DONE;
			cvk1d_pkg::S_U0: state_d = cvk1d_pkg::S_U1;
			cvk1d_pkg::S_U1: begin
				if (s_q[32] || (s_q == '0)) begin
					state_d = cvk1d_pkg::S_DONE;
				end else begin
					mul_a   = 33'(y_abs);
					mul_b   = 33'(y_abs);
					state_d = cvk1d_pkg::S_SC_START;
				end
			end
			cvk1d_pkg::S_SC_START: state_d = cvk1d_pkg::S_DIV;
			cvk1d_pkg::S_DIV: begin
				if (cnt_q == CNT_W'(cvk1d_pkg::DIV_W - 1)) begin
					state_d = cvk1d_pkg::S_DIVEND;
				end
			end
			cvk1d_pkg::S_DIVEND: begin
				case (dsel_q)
					cvk1d_pkg::DV_SCORE:
						state_d = is_vel ? cvk1d_pkg::S_K0_START : cvk1d_pkg::S_A0;
					cvk1d_pkg::DV_K0: state_d = cvk1d_pkg::S_K1_START;
					default:          state_d = cvk1d_pkg::S_F0;
				endcase
			end
			cvk1d_pkg::S_A0: begin
				mul_a   = 33'(avg_q);
				mul_b   = 33'(cvk1d_pkg::W_ONE - wc);
				state_d = cvk1d_pkg::S_A1;
			end
			cvk1d_pkg::S_A1: begin
				mul_a   = 33'(n_psc_q);
				mul_b   = 33'(wc);
				state_d = cvk1d_pkg::S_A2;
			end
			cvk1d_pkg::S_A2:       state_d = cvk1d_pkg::S_K0_START;
			cvk1d_pkg::S_K0_START: state_d = cvk1d_pkg::S_DIV;
			cvk1d_pkg::S_K1_START: state_d = cvk1d_pkg::S_DIV;
			cvk1d_pkg::S_F0: begin
				mul_a   = 33'(k0_q);
				mul_b   = 33'(y_q);
				state_d = cvk1d_pkg::S_F1;
			end
			cvk1d_pkg::S_F1: begin
				mul_a   = 33'(k1_q);
				mul_b   = 33'(y_q);
				state_d = cvk1d_pkg::S_F2;
			end
			cvk1d_pkg::S_F2: begin
				mul_a   = is_vel ? 33'(k0_q) : 33'(om_q);
				mul_b   = is_vel ? 33'(pv_q) : 33'(pp_q);
				state_d = cvk1d_pkg::S_F3;
			end
			cvk1d_pkg::S_F3: begin
				mul_a   = is_vel ? 33'(k0_q) : 33'(om_q);
				mul_b   = is_vel ? 33'(vv_q) : 33'(pv_q);
				state_d = cvk1d_pkg::S_F4;
			end
			cvk1d_pkg::S_F4: begin
				mul_a   = is_vel ? 33'(om_q) : 33'(k1_q);
				mul_b   = is_vel ? 33'(vv_q) : 33'(pv_q);
				state_d = cvk1d_pkg::S_F5;
			end
			cvk1d_pkg::S_F5: state_d = cvk1d_pkg::S_F6;
			cvk1d_pkg::S_F6: state_d = cvk1d_pkg::S_DONE;
			cvk1d_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = cvk1d_pkg::S_IDLE;
				end
			end
			default: state_d = cvk1d_pkg::S_IDLE;
		endcase
	end

	// filter state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			vel_q       <= '0;
			pp_q        <= '0;
			pv_q        <= '0;
			vv_q        <= '0;
			psc_q       <= '0;
			vsc_q       <= '0;
			avg_q       <= AVG_INIT;
			out_valid_q <= 1'b0;
			weight_q    <= cvk1d_pkg::W_RESET;
		end else begin
			if (cfg_wr_en) begin
				weight_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// commit the finished word once the output register is free
			if ((state_q == cvk1d_pkg::S_DONE) && (!out_valid_q || out_ready)) begin
				pos_q       <= n_pos_q;
				vel_q       <= n_vel_q;
				pp_q        <= n_pp_q;
				pv_q        <= n_pv_q;
				vv_q        <= n_vv_q;
				psc_q       <= n_psc_q;
				vsc_q       <= n_vsc_q;
				avg_q       <= n_avg_q;
				out_valid_q <= 1'b1;
			end
		end
	end

	// result flags
	always_ff @(posedge clk) begin
		if ((state_q == cvk1d_pkg::S_DONE) && (!out_valid_q || out_ready)) begin
			skip_out_q <= skip_q;
			sat_out_q  <= sat_q;
		end
	end

	// shared multiplier and its rounding stage
	always_ff @(posedge clk) begin
		prod_q  <= 66'(mul_a) * 66'(mul_b);
		m_q     <= rnd_s.val;
		m_ovf_q <= rnd_s.ovf;
	end

	// datapath steps
	always_ff @(posedge clk) begin
		case (state_q)
			cvk1d_pkg::S_IDLE: begin
				if (accept) begin
					op_q    <= cvk1d_pkg::op_t'(op);
					dt_q    <= time_step;
					qp_q    <= pos_noise;
					qv_q    <= vel_noise;
					z_q     <= measurement;
					r_q     <= meas_variance;
					sat_q   <= 1'b0;
					skip_q  <= 1'b0;
					if (cvk1d_pkg::op_t'(op) == cvk1d_pkg::OP_RESET) begin
						n_pos_q <= init_pos;
						n_vel_q <= init_vel;
						n_pp_q  <= 32'(init_pos_var);
						n_pv_q  <= '0;
						n_vv_q  <= 32'(init_vel_var);
						n_psc_q <= '0;
						n_vsc_q <= '0;
						n_avg_q <= '0;
					end else begin
						n_pos_q <= pos_q;
						n_vel_q <= vel_q;
						n_pp_q  <= pp_q;
						n_pv_q  <= pv_q;
						n_vv_q  <= vv_q;
						n_psc_q <= psc_q;
						n_vsc_q <= vsc_q;
						n_avg_q <= avg_q;
					end
				end
			end
			// predict
			cvk1d_pkg::S_P2: begin
				n_pos_q <= t_pos.val;
				sat_q   <= sat_q | m_ovf_q | t_pos.ovf;
			end
			cvk1d_pkg::S_P3: begin
				acc_q <= 50'(pp_q) + (50'(m_q) <<< 1) + 50'(qp_q);
				sat_q <= sat_q | m_ovf_q;
			end
			cvk1d_pkg::S_P4: begin
				sat_q <= sat_q | m_ovf_q;
			end
			cvk1d_pkg::S_P5: begin
				n_pv_q <= t_pv_p.val;
				sat_q  <= sat_q | m_ovf_q | t_pv_p.ovf;
			end
			cvk1d_pkg::S_P6: begin
				n_pp_q <= t_pp_p.val;
				n_vv_q <= t_vv_p.val;
				sat_q  <= sat_q | m_ovf_q | t_pp_p.ovf | t_vv_p.ovf;
			end
			// innovation and its variance
			cvk1d_pkg::S_U0: begin
				y_q   <= y_s.val;
				sat_q <= sat_q | y_s.ovf;
				s_q   <= 33'(is_vel ? vv_q : pp_q) + 33'(r_q);
			end
			cvk1d_pkg::S_U1: begin
				if (s_q[32] || (s_q == '0)) begin
					skip_q <= 1'b1;
				end
			end
			// load the divider
			cvk1d_pkg::S_SC_START: begin
				div_q  <= 64'(prod_q) + 64'(s_half);
				rem_q  <= '0;
				cnt_q  <= '0;
				dsel_q <= cvk1d_pkg::DV_SCORE;
				dneg_q <= 1'b0;
			end
			cvk1d_pkg::S_K0_START: begin
				div_q  <= (64'(a_abs0) << FRAC_BITS) + 64'(s_half);
				rem_q  <= '0;
				cnt_q  <= '0;
				dsel_q <= cvk1d_pkg::DV_K0;
				dneg_q <= is_vel ? pv_q[31] : pp_q[31];
			end
			cvk1d_pkg::S_K1_START: begin
				div_q  <= (64'(a_abs1) << FRAC_BITS) + 64'(s_half);
				rem_q  <= '0;
				cnt_q  <= '0;
				dsel_q <= cvk1d_pkg::DV_K1;
				dneg_q <= is_vel ? vv_q[31] : pv_q[31];
			end
			// one quotient bit per cycle
			cvk1d_pkg::S_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				if (!div_tr[34]) begin
					rem_q <= div_tr[32:0];
					div_q <= {div_q[cvk1d_pkg::DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= div_sh[32:0];
					div_q <= {div_q[cvk1d_pkg::DIV_W-2:0], 1'b0};
				end
			end
			cvk1d_pkg::S_DIVEND: begin
				case (dsel_q)
					cvk1d_pkg::DV_SCORE: begin
						if (|div_q[cvk1d_pkg::DIV_W-1:31]) begin
							sat_q <= 1'b1;
							if (is_vel) n_vsc_q <= cvk1d_pkg::SCORE_MAX;
							else        n_psc_q <= cvk1d_pkg::SCORE_MAX;
						end else begin
							if (is_vel) n_vsc_q <= div_q[30:0];
							else        n_psc_q <= div_q[30:0];
						end
					end
					cvk1d_pkg::DV_K0: begin
						k0_q  <= k_val;
						sat_q <= sat_q | k_ovf;
					end
					default: begin
						k1_q  <= k_val;
						sat_q <= sat_q | k_ovf;
					end
				endcase
			end
			// smoothed position score
			cvk1d_pkg::S_A1: begin
				acc_q <= 50'(prod_q);
			end
			cvk1d_pkg::S_A2: begin
				n_avg_q <= 31'((acc_q + 50'(prod_q) + 50'sd32768) >>> 16);
			end
			// apply the gains
			cvk1d_pkg::S_F0: begin
				om_q  <= om_s.val;
				sat_q <= sat_q | om_s.ovf;
			end
			cvk1d_pkg::S_F2: begin
				n_pos_q <= t_pos.val;
				sat_q   <= sat_q | m_ovf_q | t_pos.ovf;
			end
			cvk1d_pkg::S_F3: begin
				n_vel_q <= t_vel.val;
				sat_q   <= sat_q | m_ovf_q | t_vel.ovf;
			end
			cvk1d_pkg::S_F4: begin
				if (is_vel) begin
					n_pp_q <= t_pp_u.val;
					sat_q  <= sat_q | m_ovf_q | t_pp_u.ovf;
				end else begin
					n_pp_q <= m_q;
					sat_q  <= sat_q | m_ovf_q;
				end
			end
			cvk1d_pkg::S_F5: begin
				if (is_vel) begin
					n_pv_q <= t_pv_u.val;
					sat_q  <= sat_q | m_ovf_q | t_pv_u.ovf;
				end else begin
					n_pv_q <= m_q;
					sat_q  <= sat_q | m_ovf_q;
				end
			end
			cvk1d_pkg::S_F6: begin
				if (is_vel) begin
					n_vv_q <= m_q;
					sat_q  <= sat_q | m_ovf_q;
				end else begin
					n_vv_q <= t_vv_u.val;
					sat_q  <= sat_q | m_ovf_q | t_vv_u.ovf;
				end
			end
			default: begin
			end
		endcase
	end

	// drive the result word
	assign out_valid     = out_valid_q;
	assign est_pos       = pos_q;
	assign est_vel       = vel_q;
	assign var_pos       = pp_q;
	assign cov_cross     = pv_q;
	assign var_vel       = vv_q;
	assign pos_score     = psc_q;
	assign vel_score     = vsc_q;
	assign pos_score_avg = avg_q;
	assign skipped       = skip_out_q;
	assign saturated     = sat_out_q;

endmodule
